[rtl/mqtt_rpk_pkg.sv]
package mqtt_rpk_pkg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  data_byte;
        logic [2:0]  byte_role;
        logic [3:0]  packet_kind;
        logic [27:0] remaining_length;
        logic [15:0] topic_length;
        logic [15:0] message_id;
        logic        packet_end;
        logic        packet_dropped;
        logic        last_of_run;
    } t_out_req;

    localparam logic [1:0] K_BYTE = 2'd0;
    localparam logic [1:0] K_TICK = 2'd1;
    localparam logic [1:0] K_SEND = 2'd2;
    localparam logic [1:0] K_START = 2'd3;

    localparam logic [1:0] OK_ANN = 2'd0;
    localparam logic [1:0] OK_TX = 2'd1;
    localparam logic [1:0] OK_DISC = 2'd2;

    localparam logic [2:0] R_HDR = 3'd0;
    localparam logic [2:0] R_LEN = 3'd1;
    localparam logic [2:0] R_TLEN = 3'd2;
    localparam logic [2:0] R_TOPIC = 3'd3;
    localparam logic [2:0] R_MID = 3'd4;
    localparam logic [2:0] R_PAY = 3'd5;

    localparam logic [1:0] CFG_KEEPALIVE = 2'd0;
    localparam logic [1:0] CFG_MAXPKT = 2'd1;
    localparam logic [1:0] CFG_STREAM = 2'd2;

    localparam logic [3:0] T_PUBLISH = 4'h3;
    localparam logic [3:0] T_PINGREQ = 4'hC;
    localparam logic [3:0] T_PINGRESP = 4'hD;

    localparam logic [26:0] IDLE_MAX = 27'h7FFFFFF;

    // Jobs queued by the front part: an optional annotation plus an optional
    // canned reply that the back part expands into transmit bytes or a disconnect.
    typedef enum logic [2:0] {
        RSP_NONE,
        RSP_PUBACK,
        RSP_PINGRESP,
        RSP_PINGREQ,
        RSP_DISC
    } t_rsp;

    typedef struct packed {
        logic        has_ann;
        t_out_req    ann;
        t_rsp        rsp;
        logic [15:0] mid;
    } t_job;

endpackage

[rtl/mqtt_rpk_front.sv]
module mqtt_rpk_front
    import mqtt_rpk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_req     i_req,
    output logic        o_stall,
    input  logic [15:0] i_keepalive,
    input  logic [15:0] i_maxpkt,
    input  logic        i_stream,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_full
);

    logic [1:0]  r_phase;
    logic [7:0]  r_type;
    logic [27:0] r_len;
    logic [2:0]  r_dig;
    logic [27:0] r_body;
    logic [15:0] r_tlen;
    logic [15:0] r_mid;
    logic        r_ping;
    logic [26:0] r_in;
    logic [26:0] r_out;

    logic [1:0]  n_phase;
    logic [7:0]  n_type;
    logic [27:0] n_len;
    logic [2:0]  n_dig;
    logic [27:0] n_body;
    logic [15:0] n_tlen;
    logic [15:0] n_mid;
    logic        n_ping;
    logic [26:0] n_in;
    logic [26:0] n_out;

    logic        acc;
    logic [7:0]  b;
    logic [2:0]  role;
    logic        fin;
    logic        drop;
    logic [28:0] total;
    logic [27:0] t_idx;
    logic [27:0] t_rel;
    logic [26:0] in_inc;
    logic [26:0] out_inc;
    logic [26:0] thr;

    assign o_stall = i_job_full;
    assign acc = i_valid && !i_job_full;
    assign b = i_req.rx_byte;
    assign thr = 27'(i_keepalive) * 27'd1000;

    always_comb begin
        n_phase = r_phase;
        n_type = r_type;
        n_len = r_len;
        n_dig = r_dig;
        n_body = r_body;
        n_tlen = r_tlen;
        n_mid = r_mid;
        n_ping = r_ping;
        n_in = r_in;
        n_out = r_out;
        role = R_HDR;
        fin = 1'b0;
        drop = 1'b0;
        total = '0;
        t_idx = r_body - 28'd2;
        t_rel = t_idx - 28'(r_tlen);
        in_inc = (r_in < IDLE_MAX) ? r_in + 27'd1 : r_in;
        out_inc = (r_out < IDLE_MAX) ? r_out + 27'd1 : r_out;
        o_job = '0;
        o_job_valid = 1'b0;
        case (i_req.kind)
            K_BYTE: begin
                o_job_valid = 1'b1;
                o_job.has_ann = 1'b1;
                if (r_phase == 2'd0) begin
                    n_type = b;
                    n_len = '0;
                    n_dig = '0;
                    n_body = '0;
                    n_tlen = '0;
                    n_mid = '0;
                    n_phase = 2'd1;
                    role = R_HDR;
                end else if (r_phase == 2'd1) begin
                    role = R_LEN;
                    case (r_dig[1:0])
                        2'd0: n_len = r_len + 28'(b[6:0]);
                        2'd1: n_len = r_len + (28'(b[6:0]) << 7);
                        2'd2: n_len = r_len + (28'(b[6:0]) << 14);
                        default: n_len = r_len + (28'(b[6:0]) << 21);
                    endcase
                    n_dig = r_dig + 3'd1;
                    if (!(b[7] && n_dig < 3'd4)) begin
                        if (n_len == '0) begin
                            fin = 1'b1;
                        end else begin
                            n_phase = 2'd2;
                        end
                    end
                end else begin
                    role = R_PAY;
                    if (r_type[7:4] == T_PUBLISH) begin
                        if (r_body == 28'd0) begin
                            role = R_TLEN;
                            n_tlen = {b, 8'h00};
                        end else if (r_body == 28'd1) begin
                            role = R_TLEN;
                            n_tlen = r_tlen | 16'(b);
                        end else if (t_idx < 28'(r_tlen)) begin
                            role = R_TOPIC;
                        end else if (r_type[2:1] != 2'd0 && t_rel < 28'd2) begin
                            role = R_MID;
                            if (t_rel == 28'd0) begin
                                n_mid = {b, 8'h00};
                            end else begin
                                n_mid = r_mid | 16'(b);
                            end
                        end
                    end
                    n_body = r_body + 28'd1;
                    if (n_body >= r_len) begin
                        fin = 1'b1;
                    end
                end
                if (fin) begin
                    total = 29'd1 + 29'(n_dig) + 29'(n_len);
                    drop = !i_stream && total > 29'(i_maxpkt);
                    n_phase = 2'd0;
                    if (!drop) begin
                        n_in = '0;
                        if (n_type[7:4] == T_PUBLISH && n_type[2:1] == 2'd1) begin
                            o_job.rsp = RSP_PUBACK;
                            n_out = '0;
                        end else if (n_type[7:4] == T_PINGREQ) begin
                            o_job.rsp = RSP_PINGRESP;
                        end else if (n_type[7:4] == T_PINGRESP) begin
                            n_ping = 1'b0;
                        end
                    end
                end
                o_job.mid = n_mid;
                o_job.ann.out_kind = OK_ANN;
                o_job.ann.data_byte = b;
                o_job.ann.byte_role = role;
                o_job.ann.packet_kind = n_type[7:4];
                o_job.ann.remaining_length = n_len;
                o_job.ann.topic_length = n_tlen;
                o_job.ann.message_id = n_mid;
                o_job.ann.packet_end = fin;
                o_job.ann.packet_dropped = drop;
            end
            K_TICK: begin
                n_in = in_inc;
                n_out = out_inc;
                if (in_inc > thr || out_inc > thr) begin
                    o_job_valid = 1'b1;
                    o_job.rsp = r_ping ? RSP_DISC : RSP_PINGREQ;
                    n_ping = 1'b1;
                    n_in = '0;
                    n_out = '0;
                end
            end
            K_SEND: begin
                n_out = '0;
            end
            default: begin
                n_phase = 2'd0;
                n_in = '0;
                n_out = '0;
                n_ping = 1'b0;
            end
        endcase
        if (!acc) begin
            o_job_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_type <= '0;
            r_len <= '0;
            r_dig <= '0;
            r_body <= '0;
            r_tlen <= '0;
            r_mid <= '0;
            r_ping <= 1'b0;
            r_in <= '0;
            r_out <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_type <= n_type;
            r_len <= n_len;
            r_dig <= n_dig;
            r_body <= n_body;
            r_tlen <= n_tlen;
            r_mid <= n_mid;
            r_ping <= n_ping;
            r_in <= n_in;
            r_out <= n_out;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3) else $error("parser phase out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == 2'd1 |-> r_dig <= 3'd3) else $error("too many length digits");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> acc) else $error("job without accepted request");

endmodule

[rtl/mqtt_rpk_queue.sv]
module mqtt_rpk_queue
    import mqtt_rpk_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_data,
    output logic o_full,
    output logic o_empty,
    input  logic i_rd,
    output t_job o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [AW:0]     r_cnt;

    assign o_full = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr && !o_full) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_rd && !o_empty) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_wr && !o_full) - (AW+1)'(i_rd && !o_empty);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");

endmodule

[rtl/mqtt_rpk_back.sv]
module mqtt_rpk_back
    import mqtt_rpk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_job     i_job,
    output logic     o_pop,
    output logic     o_valid,
    output t_out_req o_req,
    input  logic     i_stall
);

    logic [2:0] r_step;
    logic       r_valid;
    t_out_req   r_req;
    logic [2:0] nsteps;
    logic [2:0] first;
    logic [2:0] step;
    t_out_req   cur;
    logic       load;
    logic       last;

    assign o_valid = r_valid;
    assign o_req = r_req;

    always_comb begin
        case (i_job.rsp)
            RSP_PUBACK: nsteps = 3'd4;
            RSP_PINGRESP: nsteps = 3'd2;
            RSP_PINGREQ: nsteps = 3'd2;
            RSP_DISC: nsteps = 3'd1;
            default: nsteps = 3'd0;
        endcase
        first = i_job.has_ann ? 3'd0 : 3'd1;
        step = (r_step == 3'd0) ? first : r_step;
        cur = '0;
        cur.out_kind = OK_TX;
        if (step == 3'd0) begin
            cur = i_job.ann;
        end else begin
            case (i_job.rsp)
                RSP_PUBACK: begin
                    case (step)
                        3'd1: cur.data_byte = 8'h40;
                        3'd2: cur.data_byte = 8'h02;
                        3'd3: cur.data_byte = i_job.mid[15:8];
                        default: cur.data_byte = i_job.mid[7:0];
                    endcase
                end
                RSP_PINGRESP: cur.data_byte = (step == 3'd1) ? 8'hD0 : 8'h00;
                RSP_PINGREQ: cur.data_byte = (step == 3'd1) ? 8'hC0 : 8'h00;
                default: cur.out_kind = OK_DISC;
            endcase
        end
        last = step >= nsteps;
        cur.last_of_run = last;
        load = !i_empty && (!r_valid || !i_stall);
        o_pop = load && last;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req <= cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                r_step <= last ? 3'd0 : step + 3'd1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= 3'd4) else $error("response step out of range");

endmodule

[rtl/mqtt_receive_parser_keepalive.sv]
// MQTT 3.1 client receiver: takes one request per cycle while the job queue
// is not full (received byte, millisecond tick, local send notice or session
// start), annotates each received byte with its role, answers QoS1 PUBLISH
// with PUBACK and PINGREQ with PINGRESP, and runs the keepalive from the
// ticks. A received byte's annotation passes through the job queue and then
// the output register; the output register sends the results of a reply run
// (up to five results) one after another, while the job queue between
// parser and output keeps taking new requests until it is full (QUEUE_DEPTH).
module mqtt_receive_parser_keepalive
    import mqtt_rpk_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_req     i_data,
    output logic        o_stall,
    output logic        o_valid,
    output t_out_req    o_data,
    input  logic        i_stall,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_keepalive;
    logic [15:0] r_maxpkt;
    logic        r_stream;
    logic        job_valid;
    t_job        job_in;
    t_job        job_out;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keepalive <= 16'd15;
            r_maxpkt <= 16'd128;
            r_stream <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEEPALIVE: r_keepalive <= i_cfg_data;
                CFG_MAXPKT: r_maxpkt <= i_cfg_data;
                CFG_STREAM: r_stream <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mqtt_rpk_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_req(i_data), .o_stall(o_stall),
        .i_keepalive(r_keepalive), .i_maxpkt(r_maxpkt), .i_stream(r_stream),
        .o_job_valid(job_valid), .o_job(job_in), .i_job_full(q_full)
    );

    mqtt_rpk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(job_valid), .i_data(job_in), .o_full(q_full), .o_empty(q_empty),
        .i_rd(q_pop), .o_data(job_out)
    );

    mqtt_rpk_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(q_empty), .i_job(job_out), .o_pop(q_pop),
        .o_valid(o_valid), .o_req(o_data), .i_stall(i_stall)
    );

endmodule

[tb/sv/tb_mqtt_receive_parser_keepalive.sv]
module tb_mqtt_receive_parser_keepalive;
    import mqtt_rpk_pkg::*;

    typedef struct {
        logic [1:0] k;
        logic [7:0] b;
        bit         has;
        logic [1:0] eok;
        logic [7:0] eb;
        logic [2:0] er;
    } t_row;

    localparam int N_DIR = 26;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_in_req     i_data = '0;
    logic        o_stall;
    logic        o_valid;
    t_out_req    o_data;
    logic        i_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // Shadow copy of the receiver state and its registers.
    logic [15:0] ka_secs;
    logic [15:0] max_bytes;
    logic        stream_on;
    logic [1:0]  phase;
    logic [7:0]  type_byte;
    logic [27:0] rem_len;
    logic [2:0]  len_digits;
    logic [27:0] body_cnt;
    logic [15:0] topic_len;
    logic [15:0] msg_id;
    logic        ping_out;
    logic [26:0] idle_in;
    logic [26:0] idle_out;

    t_out_req    resp_q[$];
    t_out_req    first_pred;
    bit          first_has;
    t_row        dir_tab[0:N_DIR-1];
    int          idle_pct;
    int          stall_pct;
    int          n_mismatch;
    int          n_items;
    int          n_results;
    int          n_pubacks;
    int          n_drops;
    int          n_disc;
    int          cycles;

    always #5 i_clk = ~i_clk;

    mqtt_receive_parser_keepalive u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .o_stall(o_stall), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    function automatic void emit(logic [1:0] ok, logic [7:0] b, logic [2:0] role,
                                 logic pend, logic drop);
        t_out_req r;
        r = '0;
        r.out_kind = ok;
        r.data_byte = b;
        if (ok == OK_ANN) begin
            r.byte_role = role;
            r.packet_kind = type_byte[7:4];
            r.remaining_length = rem_len;
            r.topic_length = topic_len;
            r.message_id = msg_id;
            r.packet_end = pend;
            r.packet_dropped = drop;
        end
        resp_q.push_back(r);
    endfunction

    function automatic void close_packet(logic [7:0] b, logic [2:0] role);
        logic [31:0] total;
        logic        drop;
        total = 32'd1 + len_digits + rem_len;
        drop = !stream_on && total > max_bytes;
        emit(OK_ANN, b, role, 1'b1, drop);
        phase = 2'd0;
        if (drop) begin
            n_drops++;
            return;
        end
        idle_in = '0;
        if (type_byte[7:4] == T_PUBLISH && type_byte[2:1] == 2'b01) begin
            emit(OK_TX, 8'h40, R_HDR, 1'b0, 1'b0);
            emit(OK_TX, 8'h02, R_HDR, 1'b0, 1'b0);
            emit(OK_TX, msg_id[15:8], R_HDR, 1'b0, 1'b0);
            emit(OK_TX, msg_id[7:0], R_HDR, 1'b0, 1'b0);
            idle_out = '0;
            n_pubacks++;
        end else if (type_byte[7:4] == T_PINGREQ) begin
            emit(OK_TX, 8'hD0, R_HDR, 1'b0, 1'b0);
            emit(OK_TX, 8'h00, R_HDR, 1'b0, 1'b0);
        end else if (type_byte[7:4] == T_PINGRESP) begin
            ping_out = 1'b0;
        end
    endfunction

    function automatic void take_byte(logic [7:0] b);
        logic [27:0] idx;
        logic [27:0] t;
        logic [2:0]  role;
        if (phase == 2'd0) begin
            type_byte = b;
            rem_len = '0;
            len_digits = '0;
            body_cnt = '0;
            topic_len = '0;
            msg_id = '0;
            phase = 2'd1;
            emit(OK_ANN, b, R_HDR, 1'b0, 1'b0);
        end else if (phase == 2'd1) begin
            rem_len = rem_len + (28'(b[6:0]) << (7 * len_digits[1:0]));
            len_digits = len_digits + 3'd1;
            if (b[7] && len_digits < 3'd4) begin
                emit(OK_ANN, b, R_LEN, 1'b0, 1'b0);
            end else if (rem_len == '0) begin
                close_packet(b, R_LEN);
            end else begin
                phase = 2'd2;
                emit(OK_ANN, b, R_LEN, 1'b0, 1'b0);
            end
        end else begin
            idx = body_cnt;
            role = R_PAY;
            if (type_byte[7:4] == T_PUBLISH) begin
                if (idx == 28'd0) begin
                    role = R_TLEN;
                    topic_len = {b, 8'h00};
                end else if (idx == 28'd1) begin
                    role = R_TLEN;
                    topic_len = topic_len | 16'(b);
                end else begin
                    t = idx - 28'd2;
                    if (t < 28'(topic_len)) begin
                        role = R_TOPIC;
                    end else begin
                        t = t - 28'(topic_len);
                        if (type_byte[2:1] != 2'b00 && t < 28'd2) begin
                            role = R_MID;
                            if (t == 28'd0) msg_id = {b, 8'h00};
                            else msg_id = msg_id | 16'(b);
                        end
                    end
                end
            end
            body_cnt = body_cnt + 28'd1;
            if (body_cnt >= rem_len) close_packet(b, role);
            else emit(OK_ANN, b, role, 1'b0, 1'b0);
        end
    endfunction

    function automatic void predict(logic [1:0] k, logic [7:0] b);
        int          n0;
        logic [31:0] thr;
        n0 = resp_q.size();
        case (k)
            K_BYTE: begin
                take_byte(b);
            end
            K_TICK: begin
                thr = 32'(ka_secs) * 32'd1000;
                if (idle_in < IDLE_MAX) idle_in = idle_in + 27'd1;
                if (idle_out < IDLE_MAX) idle_out = idle_out + 27'd1;
                if (32'(idle_in) > thr || 32'(idle_out) > thr) begin
                    if (ping_out) begin
                        emit(OK_DISC, 8'h00, R_HDR, 1'b0, 1'b0);
                        n_disc++;
                    end else begin
                        emit(OK_TX, 8'hC0, R_HDR, 1'b0, 1'b0);
                        emit(OK_TX, 8'h00, R_HDR, 1'b0, 1'b0);
                        ping_out = 1'b1;
                    end
                    idle_in = '0;
                    idle_out = '0;
                end
            end
            K_SEND: begin
                idle_out = '0;
            end
            default: begin
                phase = 2'd0;
                idle_in = '0;
                idle_out = '0;
                ping_out = 1'b0;
            end
        endcase
        if (resp_q.size() > n0) resp_q[$].last_of_run = 1'b1;
        first_has = resp_q.size() > n0;
        if (first_has) first_pred = resp_q[n0];
    endfunction

    task automatic send_req(logic [1:0] k, logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data.kind = k;
        i_data.rx_byte = b;
        do @(posedge i_clk); while (o_stall);
        predict(k, b);
        n_items++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain();
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KEEPALIVE: ka_secs = val;
            CFG_MAXPKT: max_bytes = val;
            default: stream_on = val[0];
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_packet();
        logic [7:0] hdr;
        logic [7:0] body[$];
        int         sel;
        int         len;
        int         tl;
        int         cut;
        sel = $urandom_range(9);
        body = {};
        if (sel < 5) begin
            hdr = {T_PUBLISH, 4'($urandom_range(15))};
            tl = $urandom_range(4);
            body.push_back(8'(tl >> 8));
            body.push_back(8'(tl));
            repeat (tl) body.push_back(8'($urandom_range(255)));
            if (hdr[2:1] != 2'b00) repeat (2) body.push_back(8'($urandom_range(255)));
            repeat ($urandom_range(5)) body.push_back(8'($urandom_range(255)));
        end else begin
            if (sel == 5) hdr = {T_PINGREQ, 4'($urandom_range(15))};
            else if (sel == 6) hdr = {T_PINGRESP, 4'($urandom_range(15))};
            else hdr = 8'($urandom_range(255));
            repeat ($urandom_range(4)) body.push_back(8'($urandom_range(255)));
        end
        len = body.size();
        if ($urandom_range(7) == 0) len = $urandom_range(12);
        while (body.size() < len) body.push_back(8'($urandom_range(255)));
        cut = ($urandom_range(9) == 0) ? $urandom_range(len) : -1;
        send_req(K_BYTE, hdr);
        if (len > 127) begin
            send_req(K_BYTE, 8'(len % 128) | 8'h80);
            send_req(K_BYTE, 8'(len / 128));
        end else begin
            send_req(K_BYTE, 8'(len));
        end
        for (int i = 0; i < len; i++) begin
            if (i == cut) begin
                send_req(K_START, 8'($urandom_range(255)));
                return;
            end
            send_req(K_BYTE, body[i]);
        end
    endtask

    task automatic random_phase(int n_target);
        int start;
        start = n_items;
        while (n_items - start < n_target) begin
            case ($urandom_range(11))
                0: send_req(K_TICK, 8'($urandom_range(255)));
                1: send_req(K_SEND, 8'($urandom_range(255)));
                2: send_req(2'($urandom_range(3)), 8'($urandom_range(255)));
                3: drain();
                default: send_packet();
            endcase
        end
    endtask

    task automatic tick_burst(int n);
        repeat (n) begin
            if ($urandom_range(199) == 0) send_req(K_SEND, 8'h00);
            send_req(K_TICK, 8'($urandom_range(255)));
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_req e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (resp_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %h", o_data);
            end else begin
                e = resp_q.pop_front();
                if (o_data !== e) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("mismatch: exp %h got %h", e, o_data);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        dir_tab = '{
            '{K_BYTE, 8'h32, 1, OK_ANN, 8'h32, R_HDR},
            '{K_BYTE, 8'h07, 1, OK_ANN, 8'h07, R_LEN},
            '{K_BYTE, 8'h00, 1, OK_ANN, 8'h00, R_TLEN},
            '{K_BYTE, 8'h01, 1, OK_ANN, 8'h01, R_TLEN},
            '{K_BYTE, 8'h61, 1, OK_ANN, 8'h61, R_TOPIC},
            '{K_BYTE, 8'h12, 1, OK_ANN, 8'h12, R_MID},
            '{K_BYTE, 8'h34, 1, OK_ANN, 8'h34, R_MID},
            '{K_BYTE, 8'hFF, 1, OK_ANN, 8'hFF, R_PAY},
            '{K_BYTE, 8'h00, 1, OK_ANN, 8'h00, R_PAY},
            '{K_BYTE, 8'hC0, 1, OK_ANN, 8'hC0, R_HDR},
            '{K_BYTE, 8'h00, 1, OK_ANN, 8'h00, R_LEN},
            '{K_BYTE, 8'hD0, 1, OK_ANN, 8'hD0, R_HDR},
            '{K_BYTE, 8'h00, 1, OK_ANN, 8'h00, R_LEN},
            '{K_TICK, 8'hFF, 0, OK_ANN, 8'h00, R_HDR},
            '{K_SEND, 8'hAA, 0, OK_ANN, 8'h00, R_HDR},
            '{K_BYTE, 8'h3D, 1, OK_ANN, 8'h3D, R_HDR},
            '{K_BYTE, 8'h02, 1, OK_ANN, 8'h02, R_LEN},
            '{K_BYTE, 8'hFF, 1, OK_ANN, 8'hFF, R_TLEN},
            '{K_BYTE, 8'hFF, 1, OK_ANN, 8'hFF, R_TLEN},
            '{K_BYTE, 8'h20, 1, OK_ANN, 8'h20, R_HDR},
            '{K_BYTE, 8'hFF, 1, OK_ANN, 8'hFF, R_LEN},
            '{K_BYTE, 8'hFF, 1, OK_ANN, 8'hFF, R_LEN},
            '{K_BYTE, 8'hFF, 1, OK_ANN, 8'hFF, R_LEN},
            '{K_BYTE, 8'hFF, 1, OK_ANN, 8'hFF, R_LEN},
            '{K_START, 8'h55, 0, OK_ANN, 8'h00, R_HDR},
            '{K_BYTE, 8'h00, 1, OK_ANN, 8'h00, R_HDR}
        };
        ka_secs = 16'd15;
        max_bytes = 16'd128;
        stream_on = 1'b0;
        phase = '0;
        type_byte = '0;
        rem_len = '0;
        len_digits = '0;
        body_cnt = '0;
        topic_len = '0;
        msg_id = '0;
        ping_out = 1'b0;
        idle_in = '0;
        idle_out = '0;
        first_pred = '0;
        first_has = 1'b0;
        n_mismatch = 0;
        n_items = 0;
        n_results = 0;
        n_pubacks = 0;
        n_drops = 0;
        n_disc = 0;
        cycles = 0;
        idle_pct = 23;
        stall_pct = 73;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            send_req(dir_tab[i].k, dir_tab[i].b);
            if (dir_tab[i].has && (!first_has ||
                    first_pred.out_kind != dir_tab[i].eok ||
                    first_pred.data_byte != dir_tab[i].eb ||
                    first_pred.byte_role != dir_tab[i].er)) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("directed row %0d: wrong prediction", i);
            end
        end
        drain();

        // Zero keepalive and a small packet limit: every tick pings or
        // disconnects, and most packets are dropped.
        cfg_write(CFG_KEEPALIVE, 16'd0);
        cfg_write(CFG_MAXPKT, 16'd8);
        cfg_write(CFG_STREAM, 16'd0);
        tick_burst(4);
        random_phase(20);
        tick_burst(4);
        send_req(K_START, 8'h00);
        drain();

        idle_pct = 73;
        stall_pct = 23;
        cfg_write(CFG_KEEPALIVE, 16'd65535);
        cfg_write(CFG_MAXPKT, 16'd65535);
        cfg_write(CFG_STREAM, 16'd1);
        random_phase(25);
        drain();

        idle_pct = 0;
        stall_pct = 0;
        cfg_write(CFG_KEEPALIVE, 16'd1);
        cfg_write(CFG_MAXPKT, 16'd20);
        cfg_write(CFG_STREAM, 16'd0);
        random_phase(30);
        drain();

        $display("covered %0d requests and %0d results: %0d PUBACK runs, %0d drops,",
                 n_items, n_results, n_pubacks, n_drops);
        $display("%0d disconnect requests, over four register settings", n_disc);
        if (n_mismatch == 0 && resp_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, resp_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mqtt_rpk_pkg.sv
rtl/mqtt_rpk_front.sv
rtl/mqtt_rpk_queue.sv
rtl/mqtt_rpk_back.sv
rtl/mqtt_receive_parser_keepalive.sv
tb/sv/tb_mqtt_receive_parser_keepalive.sv
